/* rtl/mbc_pkg.sv */
// Shared types, constants and helpers for the MTI binomial canceller.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package mbc_pkg;

  localparam int MAX_PULSES  = 64;
  localparam int MAX_GATES   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 6;
  localparam int PULSE_W     = 6;
  localparam int GATE_W      = 10;
  localparam int ADDR_W      = PULSE_W + GATE_W;
  localparam int PCNT_W      = 7;
  localparam int GCNT_W      = 11;
  localparam int MODE_W      = 3;
  localparam int ACC_W       = 20;
  localparam int PROD_W      = 36;
  localparam int DIVCNT_W    = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GATES  = 2'd2;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DC    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TWO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FOUR  = 3'd4;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [PCNT_W-1:0] PULSES_RESET = 7'd16;
  localparam logic [GCNT_W-1:0] GATES_RESET  = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WR_ADD,
    ST_TAP_ADDR,
    ST_TAP_ACC,
    ST_SCALE,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic store_wr;
    logic sum_set;
    logic sum_add;
    logic acc_clr;
    logic acc_step;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic wr_ok;
    logic rd_ok;
    logic p_zero;
    logic has_order;
    logic dc_mode;
    logic last_tap;
    logic div_last;
    logic out_free;
  } stat_t;

  // Binomial coefficient of tap t for a canceller of the given order
  function automatic logic signed [2:0] coef(input logic [1:0] order, input logic [1:0] t);
    logic signed [2:0] c;
    c = 3'sd0;
    case (order)
      2'd0: c = (t == 2'd0) ? 3'sd1 : 3'sd0;
      2'd1: c = (t == 2'd0) ? 3'sd1 : ((t == 2'd1) ? -3'sd1 : 3'sd0);
      2'd2: c = (t == 2'd1) ? -3'sd2 : ((t == 2'd3) ? 3'sd0 : 3'sd1);
      2'd3: begin
        case (t)
          2'd0: c = 3'sd1;
          2'd1: c = -3'sd3;
          2'd2: c = 3'sd3;
          default: c = -3'sd1;
        endcase
      end
      default: c = 3'sd0;
    endcase
    return c;
  endfunction

  // Q15 value of 1/sqrt(sum of squared coefficients)
  function automatic logic [14:0] norm_q15(input logic [1:0] order);
    logic [14:0] n;
    case (order)
      2'd1: n = 15'd23170;
      2'd2: n = 15'd13377;
      2'd3: n = 15'd7327;
      default: n = 15'd0;
    endcase
    return n;
  endfunction

  // Saturate to a signed sample
  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
    lo = -hi - PROD_W'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/mti_binomial_canceller_core.sv */
// Sequencing: an in-range write is stored in its decode state, where a pulse-0 write
// also sets its gate sum; any other write adds to the gate sum in a further state.
// A read is decoded, fetches and accumulates its taps serially, then passes the Q15
// scaler or, in DC mode, the bit-serial mean divider; an out-of-range read goes straight
// to its result, which waits while the output is stalled. One transaction at a time.
// Reset (synchronous): clears control and the output valid and restores config
// defaults; sample and sum memories are not cleared.
`default_nettype none
module mti_binomial_canceller_core
  import mbc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // pulse_index[5:0], gate_index[15:6], sample_re[31:16], sample_im[47:32]
  input  wire  [47:0]           s_tdata,
  // req_type[0]
  input  wire                   s_tuser,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // out_re[15:0], out_im[31:16], valid_pulses[38:32], zero [39]
  output logic [39:0]           m_tdata,
  // status[0]
  output logic                  m_tuser
);

  cmd_t  cmd;
  stat_t stat;
  logic  ready;
  logic [SAMPLE_BITS-1:0] o_re;
  logic [SAMPLE_BITS-1:0] o_im;
  logic [PCNT_W-1:0]      o_pulses;

  assign s_tready = ready;
  assign m_tdata  = {1'b0, o_pulses, o_im, o_re};

  mbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .ready    (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_req     (s_tuser),
    .in_pulse   (s_tdata[5:0]),
    .in_gate    (s_tdata[15:6]),
    .in_re      (s_tdata[31:16]),
    .in_im      (s_tdata[47:32]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_re     (o_re),
    .out_im     (o_im),
    .out_pulses (o_pulses),
    .out_status (m_tuser)
  );

endmodule
`default_nettype wire

/* rtl/mbc_ctrl.sv */
// Controller state machine for the MTI binomial canceller.
// Depends on mbc_pkg; drives datapath commands from datapath status.
`default_nettype none
module mbc_ctrl
  import mbc_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one transaction at a time
  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat.is_read) begin
          if (stat.wr_ok) begin
            cmd.store_wr = 1'b1;
            if (stat.p_zero) begin
              cmd.sum_set = 1'b1;
              state_next  = ST_IDLE;
            end else begin
              state_next  = ST_WR_ADD;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.acc_clr = 1'b1;
          state_next  = stat.rd_ok ? ST_TAP_ADDR : ST_RESULT;
        end
      end
      ST_WR_ADD: begin
        cmd.sum_add = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_TAP_ADDR: begin
        state_next = ST_TAP_ACC;
      end
      ST_TAP_ACC: begin
        cmd.acc_step = 1'b1;
        if (!stat.last_tap) begin
          state_next = ST_TAP_ADDR;
        end else if (stat.has_order) begin
          state_next = ST_SCALE;
        end else if (stat.dc_mode) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCALE: begin
        cmd.mul    = 1'b1;
        state_next = ST_RESULT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/mbc_datapath.sv */
// Datapath of the MTI binomial canceller: config registers, sample and gate-sum
// memories, tap accumulator, Q15 scaler, serial mean divider, output register.
// Depends on mbc_pkg; commanded by mbc_ctrl.
`default_nettype none
module mbc_datapath
  import mbc_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire  [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [CFG_DATA_W-1:0]   cfg_data,
  input  wire                     in_req,
  input  wire  [PULSE_W-1:0]      in_pulse,
  input  wire  [GATE_W-1:0]       in_gate,
  input  wire  [SAMPLE_BITS-1:0]  in_re,
  input  wire  [SAMPLE_BITS-1:0]  in_im,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [SAMPLE_BITS-1:0]  out_re,
  output logic [SAMPLE_BITS-1:0]  out_im,
  output logic [PCNT_W-1:0]       out_pulses,
  output logic                    out_status
);

  // Configuration registers
  logic [MODE_W-1:0] mode;
  logic [PCNT_W-1:0] pulse_count;
  logic [GCNT_W-1:0] gate_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_OFF;
      pulse_count <= PULSES_RESET;
      gate_count  <= GATES_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:   mode        <= cfg_data[MODE_W-1:0];
        REG_PULSES: pulse_count <= cfg_data[PCNT_W-1:0];
        REG_GATES:  gate_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latched transaction
  logic                          req;
  logic [PULSE_W-1:0]            p;
  logic [GATE_W-1:0]             g;
  logic signed [SAMPLE_BITS-1:0] s_re;
  logic signed [SAMPLE_BITS-1:0] s_im;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req  <= in_req;
      p    <= in_pulse;
      g    <= in_gate;
      s_re <= in_re;
      s_im <= in_im;
    end
  end

  // Clamp counts, decode order and valid pulses
  logic [PCNT_W-1:0] np;
  logic [GCNT_W-1:0] ng;
  logic [1:0]        order;
  logic [PCNT_W-1:0] valid;

  always_comb begin
    np = pulse_count;
    if (np == '0) np = PCNT_W'(1);
    if (np > PCNT_W'(MAX_PULSES)) np = PCNT_W'(MAX_PULSES);
    ng = gate_count;
    if (ng == '0) ng = GCNT_W'(1);
    if (ng > GCNT_W'(MAX_GATES)) ng = GCNT_W'(MAX_GATES);
    order = 2'd0;
    if (mode >= MODE_TWO && mode <= MODE_FOUR && np > PCNT_W'(mode - 3'd1)) begin
      order = 2'(mode - 3'd1);
    end
    valid = np - PCNT_W'(order);
  end

  logic g_ok;
  assign g_ok = GCNT_W'(g) < ng;

  function automatic logic rd_ok_w();
    return (PCNT_W'(p) < valid) && g_ok;
  endfunction

  // Tap counter and memory addresses
  logic [1:0]         tap;
  logic [PULSE_W-1:0] tap_p;
  logic [ADDR_W-1:0]  rd_addr;

  assign tap_p   = p + PULSE_W'(order) - PULSE_W'(tap);
  assign rd_addr = {tap_p, g};

  // Sample store: {im, re}
  logic [2*SAMPLE_BITS-1:0] store_mem [MAX_PULSES*MAX_GATES];
  logic [2*SAMPLE_BITS-1:0] smp_rdata;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) store_mem[{p, g}] <= {s_im, s_re};
    smp_rdata <= store_mem[rd_addr];
  end

  // Gate sums: {im, re}, each wrapping
  logic [2*SUM_BITS-1:0] sum_mem [MAX_GATES];
  logic [2*SUM_BITS-1:0] sum_rdata;
  logic [SUM_BITS-1:0]   s_re_ext;
  logic [SUM_BITS-1:0]   s_im_ext;
  logic [SUM_BITS-1:0]   add_re;
  logic [SUM_BITS-1:0]   add_im;

  assign s_re_ext = SUM_BITS'(s_re);
  assign s_im_ext = SUM_BITS'(s_im);
  assign add_re   = sum_rdata[SUM_BITS-1:0] + s_re_ext;
  assign add_im   = sum_rdata[2*SUM_BITS-1:SUM_BITS] + s_im_ext;

  always_ff @(posedge clk) begin
    if (cmd.sum_set) begin
      sum_mem[g] <= {s_im_ext, s_re_ext};
    end else if (cmd.sum_add) begin
      sum_mem[g] <= {add_im, add_re};
    end
    sum_rdata <= sum_mem[g];
  end

  // Accumulate weighted taps
  logic signed [ACC_W-1:0]       acc_re;
  logic signed [ACC_W-1:0]       acc_im;
  logic signed [2:0]             c;
  logic signed [SAMPLE_BITS-1:0] x_re;
  logic signed [SAMPLE_BITS-1:0] x_im;
  logic signed [ACC_W-1:0]       term_re;
  logic signed [ACC_W-1:0]       term_im;

  assign c       = coef(order, tap);
  assign x_re    = smp_rdata[SAMPLE_BITS-1:0];
  assign x_im    = smp_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign term_re = c * x_re;
  assign term_im = c * x_im;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
      tap    <= '0;
    end else if (cmd.acc_step) begin
      acc_re <= acc_re + term_re;
      acc_im <= acc_im + term_im;
      tap    <= tap + 2'd1;
    end
  end

  // Scale by the Q15 norm
  logic signed [PROD_W-1:0]      prod_re;
  logic signed [PROD_W-1:0]      prod_im;
  logic signed [SAMPLE_BITS-1:0] norm_s;

  assign norm_s = {1'b0, norm_q15(order)};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_re <= acc_re * norm_s;
      prod_im <= acc_im * norm_s;
    end
  end

  // Serial restoring divide of the rounded gate-sum magnitude by the pulse count
  logic [SUM_BITS-1:0] sr;
  logic [SUM_BITS-1:0] si;
  logic [SUM_BITS-1:0] mag_sr;
  logic [SUM_BITS-1:0] mag_si;
  logic [SUM_BITS-1:0] dvd_re;
  logic [SUM_BITS-1:0] dvd_im;
  logic [PCNT_W-1:0]   rem_re;
  logic [PCNT_W-1:0]   rem_im;
  logic [PCNT_W:0]     trial_re;
  logic [PCNT_W:0]     trial_im;
  logic                q_re;
  logic                q_im;
  logic                neg_re;
  logic                neg_im;
  logic [DIVCNT_W-1:0] div_cnt;

  assign sr       = sum_rdata[SUM_BITS-1:0];
  assign si       = sum_rdata[2*SUM_BITS-1:SUM_BITS];
  assign mag_sr   = (sr[SUM_BITS-1] ? -sr : sr) + SUM_BITS'(np >> 1);
  assign mag_si   = (si[SUM_BITS-1] ? -si : si) + SUM_BITS'(np >> 1);
  assign trial_re = {rem_re, dvd_re[SUM_BITS-1]};
  assign trial_im = {rem_im, dvd_im[SUM_BITS-1]};
  assign q_re     = trial_re >= {1'b0, np};
  assign q_im     = trial_im >= {1'b0, np};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_re  <= mag_sr;
      dvd_im  <= mag_si;
      rem_re  <= '0;
      rem_im  <= '0;
      neg_re  <= sr[SUM_BITS-1];
      neg_im  <= si[SUM_BITS-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_re  <= PCNT_W'(q_re ? trial_re - {1'b0, np} : trial_re);
      rem_im  <= PCNT_W'(q_im ? trial_im - {1'b0, np} : trial_im);
      dvd_re  <= {dvd_re[SUM_BITS-2:0], q_re};
      dvd_im  <= {dvd_im[SUM_BITS-2:0], q_im};
      div_cnt <= div_cnt + DIVCNT_W'(1);
    end
  end

  // Round the scaled product, remove the mean, select the result
  logic [PROD_W-1:0]             pm_re;
  logic [PROD_W-1:0]             pm_im;
  logic [PROD_W-1:0]             r_re;
  logic [PROD_W-1:0]             r_im;
  logic signed [PROD_W-1:0]      mean_re;
  logic signed [PROD_W-1:0]      mean_im;
  logic signed [SAMPLE_BITS-1:0] y_re;
  logic signed [SAMPLE_BITS-1:0] y_im;

  always_comb begin
    pm_re   = prod_re[PROD_W-1] ? -prod_re : prod_re;
    pm_im   = prod_im[PROD_W-1] ? -prod_im : prod_im;
    r_re    = (pm_re + PROD_W'(16384)) >> 15;
    r_im    = (pm_im + PROD_W'(16384)) >> 15;
    mean_re = neg_re ? -PROD_W'(dvd_re) : PROD_W'(dvd_re);
    mean_im = neg_im ? -PROD_W'(dvd_im) : PROD_W'(dvd_im);
    if (!rd_ok_w()) begin
      y_re = '0;
      y_im = '0;
    end else if (order != 2'd0) begin
      y_re = sat(prod_re[PROD_W-1] ? -r_re : r_re);
      y_im = sat(prod_im[PROD_W-1] ? -r_im : r_im);
    end else if (mode == MODE_DC) begin
      y_re = sat(PROD_W'(acc_re) - mean_re);
      y_im = sat(PROD_W'(acc_im) - mean_im);
    end else begin
      y_re = sat(PROD_W'(acc_re));
      y_im = sat(PROD_W'(acc_im));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_re     <= y_re;
      out_im     <= y_im;
      out_pulses <= valid;
      out_status <= !rd_ok_w();
    end
  end

  // Status to the controller
  always_comb begin
    stat.is_read   = req == REQ_READ;
    stat.wr_ok     = (PCNT_W'(p) < np) && g_ok;
    stat.rd_ok     = rd_ok_w();
    stat.p_zero    = p == '0;
    stat.has_order = order != 2'd0;
    stat.dc_mode   = mode == MODE_DC;
    stat.last_tap  = tap == order;
    stat.div_last  = div_cnt == DIVCNT_W'(SUM_BITS - 1);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

/* rtl/mbc_checker.sv */
// Port-level checker for the MTI binomial canceller, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module mbc_sva_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [39:0] m_tdata,
  input wire        m_tuser
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // One transaction at a time: no accept in the cycle after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted back to back");

  // Out-of-range reads carry zero samples
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
    else $error("flagged result carries data");

  // Remaining pulse count lies in 1..64
  a_pulses: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] != 7'd0 && m_tdata[38:32] <= 7'd64)
    else $error("valid pulse count out of range");

endmodule

bind mti_binomial_canceller_core mbc_sva_checker u_mbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
